// ----- rtl/pfba_pkg.sv -----
// Package for the page frame bitmap allocator: sizes, register indexes,
// request codes and the word window type shared by the RTL modules.
// Depends on nothing.
package pfba_pkg;

   localparam int PAGES      = 65536;
   localparam int REGIONS    = 2;
   localparam int WORD_BITS  = 64;
   localparam int WORD_SHIFT = $clog2(WORD_BITS);
   localparam int WORDS      = PAGES / WORD_BITS;
   localparam int ADDR_W     = $clog2(WORDS);
   localparam int IDX_W      = 16;
   localparam int CNT_W      = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION0_START = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION0_END   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION1_START = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION1_END   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_MASK      = 3'd5;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic                  first;
      logic                  last;
      logic [WORD_SHIFT-1:0] lo;
      logic [WORD_SHIFT-1:0] hi;
   } word_window_type;

endpackage

// ----- rtl/pfba_req_if.sv -----
// Request channel of the page frame bitmap allocator.
// Depends on pfba_pkg for the field widths.
interface pfba_req_if;
   import pfba_pkg::*;

   logic             valid;
   logic             ready;
   logic             req_type;
   logic             ram_only;
   logic [IDX_W-1:0] page_index;

   modport source (output valid, req_type, ram_only, page_index, input ready);
   modport sink   (input valid, req_type, ram_only, page_index, output ready);

endinterface

// ----- rtl/pfba_rsp_if.sv -----
// Response channel of the page frame bitmap allocator.
// Depends on pfba_pkg for the field widths.
interface pfba_rsp_if;
   import pfba_pkg::*;

   logic             valid;
   logic             ready;
   logic             ok;
   logic [IDX_W-1:0] granted_page;
   logic [CNT_W-1:0] pages_in_use;

   modport source (output valid, ok, granted_page, pages_in_use, input ready);
   modport sink   (input valid, ok, granted_page, pages_in_use, output ready);

endinterface

// ----- rtl/pfba_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module pfba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pfba_word_search.sv -----
// Find-first-free search over one word of the used map, limited to the
// scan window inside the first and last words. Depends on pfba_pkg.
module pfba_word_search
   import pfba_pkg::*;
(
   input  logic [WORD_BITS-1:0]  used_word,
   input  word_window_type       window,
   output logic                  found,
   output logic [WORD_SHIFT-1:0] pos
);

   logic [WORD_BITS-1:0] free_bits;

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         free_bits[i] = !used_word[i]
                        && (!window.first || (WORD_SHIFT'(i) >= window.lo))
                        && (!window.last  || (WORD_SHIFT'(i) <= window.hi));
      end
   end

   always_comb begin
      found = |free_bits;
      pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            pos = WORD_SHIFT'(i);
         end
      end
   end

endmodule

// ----- rtl/page_frame_bitmap_allocator.sv -----
// Top level of the page frame bitmap allocator: control, hint, use count,
// configuration registers. Depends on pfba_pkg, pfba_req_if, pfba_rsp_if,
// pfba_ram and pfba_word_search.
//
//   port       direction  purpose
//   req_if     in         allocate or free request
//   rsp_if     out        grant or release result, pages in use
//   csr_*      in         region and RAM mask register writes
//
// After reset the used map is cleared one word a cycle, all 1024 words, and
// no request is taken meanwhile. A free reads the map word, then clears the
// page's bit in ST_FREE if it is in use and passes through ST_RESP to the output.
// An allocate walks the regions in ST_REGION and scans each region's map words
// through the map RAM read port in ST_SCAN, then goes to ST_RESP.
// One request is in progress at a time; a new one is taken while the previous
// response still waits in the output register.
module page_frame_bitmap_allocator
   import pfba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pfba_req_if.sink              req_if,
   pfba_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_REGION = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_FREE   = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   localparam logic [CNT_W-1:0] PAGES_C   = CNT_W'(PAGES);
   localparam logic [1:0]       REGIONS_C = 2'(REGIONS);

   logic [2:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     clear_addr_ff, clear_addr_in;
   logic [1:0]            region_ff, region_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [ADDR_W-1:0]     first_ff, first_in;
   logic [ADDR_W-1:0]     last_ff, last_in;
   logic [WORD_SHIFT-1:0] lo_ff, lo_in;
   logic [WORD_SHIFT-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0]      hint_ff, hint_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  ram_only_ff, ram_only_in;
   logic                  res_ok_ff, res_ok_in;
   logic [IDX_W-1:0]      res_page_ff, res_page_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [IDX_W-1:0]      rsp_page_ff, rsp_page_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic [1:0]            region_count_ff;
   logic [CNT_W-1:0]      region_start_ff [2];
   logic [CNT_W-1:0]      region_end_ff [2];
   logic [1:0]            ram_mask_ff;

   logic                  map_we;
   logic [ADDR_W-1:0]     map_waddr;
   logic [WORD_BITS-1:0]  map_wdata;
   logic [ADDR_W-1:0]     map_raddr;
   logic [WORD_BITS-1:0]  map_rdata;

   logic [1:0]            n_eff;
   logic                  region_active;
   logic [CNT_W-1:0]      cur_start;
   logic [CNT_W-1:0]      cur_end;
   logic                  region_skip;
   logic [CNT_W-1:0]      scan_start;
   logic [CNT_W-1:0]      scan_end;
   logic [CNT_W-1:0]      scan_last;
   logic                  region_empty;

   word_window_type       window;
   logic                  found;
   logic [WORD_SHIFT-1:0] pos;
   logic [WORD_BITS-1:0]  pos_bit;
   logic [WORD_BITS-1:0]  free_bit;
   logic                  free_in_range;
   logic                  free_used;
   logic                  req_fire;
   logic                  out_free;

   pfba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   assign window.first = (addr_ff == first_ff);
   assign window.last  = (addr_ff == last_ff);
   assign window.lo    = lo_ff;
   assign window.hi    = hi_ff;

   pfba_word_search u_search (
      .used_word (map_rdata),
      .window    (window),
      .found     (found),
      .pos       (pos)
   );

   assign req_fire = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign n_eff         = (region_count_ff > REGIONS_C) ? REGIONS_C : region_count_ff;
   assign region_active = (region_ff < n_eff);
   assign cur_start     = region_start_ff[region_ff[0]];
   assign cur_end       = region_end_ff[region_ff[0]];
   assign region_skip   = (ram_only_ff && !ram_mask_ff[region_ff[0]]) || (hint_ff > cur_end);
   assign scan_start    = (hint_ff < cur_start) ? cur_start : hint_ff;
   assign scan_end      = (cur_end > PAGES_C) ? PAGES_C : cur_end;
   assign scan_last     = scan_end - CNT_W'(1);
   assign region_empty  = (scan_start >= scan_end);

   assign pos_bit       = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos;
   assign free_bit      = {{(WORD_BITS-1){1'b0}}, 1'b1} << idx_ff[WORD_SHIFT-1:0];
   assign free_in_range = ({1'b0, idx_ff} < PAGES_C);
   assign free_used     = map_rdata[idx_ff[WORD_SHIFT-1:0]];

   assign req_if.ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      region_in     = region_ff;
      addr_in       = addr_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      hint_in       = hint_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      ram_only_in   = ram_only_ff;
      res_ok_in     = res_ok_ff;
      res_page_in   = res_page_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_count_in  = rsp_count_ff;
      map_we        = 1'b0;
      map_waddr     = addr_ff;
      map_wdata     = map_rdata;
      map_raddr     = addr_ff;

      case (state_ff)
         ST_CLEAR: begin
            map_we        = 1'b1;
            map_waddr     = clear_addr_ff;
            map_wdata     = '0;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == ADDR_W'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               ram_only_in = req_if.ram_only;
               idx_in      = req_if.page_index;
               region_in   = '0;
               map_raddr   = req_if.page_index[IDX_W-1:WORD_SHIFT];
               if (req_if.req_type == REQ_FREE) begin
                  state_in = ST_FREE;
               end else begin
                  state_in = ST_REGION;
               end
            end
         end
         ST_REGION: begin
            if (!region_active) begin
               res_ok_in   = 1'b0;
               res_page_in = '0;
               state_in    = ST_RESP;
            end else if (region_skip || region_empty) begin
               region_in = region_ff + 2'd1;
            end else begin
               map_raddr = scan_start[WORD_SHIFT+ADDR_W-1:WORD_SHIFT];
               addr_in   = scan_start[WORD_SHIFT+ADDR_W-1:WORD_SHIFT];
               first_in  = scan_start[WORD_SHIFT+ADDR_W-1:WORD_SHIFT];
               last_in   = scan_last[WORD_SHIFT+ADDR_W-1:WORD_SHIFT];
               lo_in     = scan_start[WORD_SHIFT-1:0];
               hi_in     = scan_last[WORD_SHIFT-1:0];
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (found) begin
               map_we      = 1'b1;
               map_waddr   = addr_ff;
               map_wdata   = map_rdata | pos_bit;
               hint_in     = CNT_W'({addr_ff, pos}) + CNT_W'(1);
               count_in    = count_ff + CNT_W'(1);
               res_ok_in   = 1'b1;
               res_page_in = IDX_W'({addr_ff, pos});
               state_in    = ST_RESP;
            end else if (addr_ff == last_ff) begin
               region_in = region_ff + 2'd1;
               state_in  = ST_REGION;
            end else begin
               addr_in   = addr_ff + ADDR_W'(1);
               map_raddr = addr_ff + ADDR_W'(1);
            end
         end
         ST_FREE: begin
            res_page_in = '0;
            if (free_in_range && free_used) begin
               map_we    = 1'b1;
               map_waddr = idx_ff[IDX_W-1:WORD_SHIFT];
               map_wdata = map_rdata & ~free_bit;
               if (hint_ff > {1'b0, idx_ff}) begin
                  hint_in = {1'b0, idx_ff};
               end
               count_in  = count_ff - CNT_W'(1);
               res_ok_in = 1'b1;
            end else begin
               res_ok_in = 1'b0;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_page_in  = res_page_ff;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         region_ff     <= '0;
         hint_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         region_ff     <= region_in;
         hint_ff       <= hint_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      idx_ff       <= idx_in;
      ram_only_ff  <= ram_only_in;
      res_ok_ff    <= res_ok_in;
      res_page_ff  <= res_page_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_count_ff    <= '0;
         region_start_ff[0] <= '0;
         region_end_ff[0]   <= '0;
         region_start_ff[1] <= '0;
         region_end_ff[1]   <= '0;
         ram_mask_ff        <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REGION_COUNT:  region_count_ff    <= csr_wdata[1:0];
            CSR_REGION0_START: region_start_ff[0] <= csr_wdata;
            CSR_REGION0_END:   region_end_ff[0]   <= csr_wdata;
            CSR_REGION1_START: region_start_ff[1] <= csr_wdata;
            CSR_REGION1_END:   region_end_ff[1]   <= csr_wdata;
            CSR_RAM_MASK:      ram_mask_ff        <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.ok           = rsp_ok_ff;
   assign rsp_if.granted_page = rsp_page_ff;
   assign rsp_if.pages_in_use = rsp_count_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PAGES_C)
      else $error("used page count exceeds the map size");

   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_if.ready)
      else $error("request taken during the map clearing pass");

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (addr_ff >= first_ff) && (addr_ff <= last_ff))
      else $error("map scan outside the region window");

   a_map_write_states: assert property (@(posedge clock) disable iff (reset)
      map_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_SCAN) || (state_ff == ST_FREE))
      else $error("map written outside clear, allocate or free");

   a_alloc_moves_hint: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && found |=> hint_ff == CNT_W'(res_page_ff) + CNT_W'(1))
      else $error("hint not placed after the granted page");

endmodule
